[design/starfield_projection_step_top_defines.svh]
// Assertion macros shared by the checker of the starfield projection block.
`ifndef STARFIELD_PROJECTION_STEP_TOP_DEFINES_SVH
`define STARFIELD_PROJECTION_STEP_TOP_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define SFPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A property checked while reset is applied: the cycle after reset is seen low.
`define SFPS_ASSERT_RST(lbl, cons, msg) \
	lbl: assert property (@(posedge clk) !arst_n |=> (cons)) else $error(msg);

`endif

[design/sfps_pkg.sv]
// ----------------------------------------------------------------------------
// sfps_pkg
// Types and constants shared by the starfield projection block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfps_pkg;

	localparam int IDX_W = 6;
	localparam int CFG_W = 10;
	localparam int PIX_W = 9;

	localparam logic CMD_SPAWN = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	typedef enum logic {
		REG_DISPLAY_WIDTH  = 1'b0,
		REG_DISPLAY_HEIGHT = 1'b1
	} reg_idx_t;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 10'd128;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 10'd128;
	localparam logic [CFG_W-1:0] WIDE_LIMIT   = 10'd128;

	localparam logic [8:0]  SPREAD_WIDE   = 9'd300;
	localparam logic [8:0]  SPREAD_NARROW = 9'd200;
	localparam logic [8:0]  HALF_WIDE     = 9'd150;
	localparam logic [8:0]  HALF_NARROW   = 9'd100;
	localparam logic [8:0]  DEPTH_MOD     = 9'd400;
	localparam logic [9:0]  DEPTH_BASE    = 10'd100;
	// floor(2^32 / divisor); the quotient estimate is exact or one short.
	localparam logic [31:0] RECIP_WIDE    = 32'd14316557;
	localparam logic [31:0] RECIP_NARROW  = 32'd21474836;
	localparam logic [31:0] RECIP_DEPTH   = 32'd10737418;

	localparam logic [7:0]  SCALE_WIDE    = 8'd150;
	localparam logic [7:0]  SCALE_NARROW  = 8'd100;
	localparam logic [10:0] Z_STEP        = 11'd7;

	// level / 17 equals (level * 241) >> 12 for every 8-bit level.
	localparam logic [7:0]  GRAY_RECIP    = 8'd241;
	localparam int          GRAY_SHIFT    = 12;

	localparam int DIV_STEPS   = 15;
	localparam int QUEUE_DEPTH = 8;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic signed [8:0] x;
		logic signed [8:0] y;
		logic [9:0]        z;
		logic [7:0]        level;
	} star_t;

	typedef struct packed {
		logic             cmd;
		logic             in_range;
		logic [IDX_W-1:0] idx;
		star_t            spawn;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} push_t;

	typedef struct packed {
		logic              empty;
		logic [QCNT_W-1:0] count;
		item_t             head;
	} q_status_t;

endpackage

`default_nettype wire

[design/starfield_projection_step_top.sv]
// ----------------------------------------------------------------------------
// starfield_projection_step_top
// Perspective starfield: spawns, advances and projects stars held in a table.
// ----------------------------------------------------------------------------
//  channel   handshake            word
//  command   start / busy         cmd, star_index, rand_x/y/z, rand_level
//  result    done (strobe)        pixel_valid, pixel_x, pixel_y, gray, respawned
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One command is taken per clock while busy is low; each gives one result through
// 3 front stages, queue, star RAM read, setup, 15 divide stages and output.
// A command on a star still inside the divider waits at the queue head until
// that star is written back; busy rises when queue plus front stages hold 8.
// The star RAM has no reset; a star must be spawned before it is stepped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module starfield_projection_step_top #(
	parameter int NUM_STARS = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic                       cmd,
	input  wire logic [sfps_pkg::IDX_W-1:0] star_index,
	input  wire logic [31:0]                rand_x,
	input  wire logic [31:0]                rand_y,
	input  wire logic [31:0]                rand_z,
	input  wire logic [7:0]                 rand_level,
	output logic                            done,
	output logic                            pixel_valid,
	output logic [sfps_pkg::PIX_W-1:0]      pixel_x,
	output logic [sfps_pkg::PIX_W-1:0]      pixel_y,
	output logic [7:0]                      gray,
	output logic                            respawned,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic                       cfg_index,
	input  wire logic [sfps_pkg::CFG_W-1:0] cfg_data
);

	logic [sfps_pkg::CFG_W-1:0] width_q, height_q;
	sfps_pkg::push_t            push;
	sfps_pkg::q_status_t        status;
	logic                       pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sfps_pkg::WIDTH_RESET;
			height_q <= sfps_pkg::HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sfps_pkg::REG_DISPLAY_WIDTH: begin
					width_q <= cfg_data;
				end
				sfps_pkg::REG_DISPLAY_HEIGHT: begin
					height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	sfps_front #(.NUM_STARS(NUM_STARS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.star_index (star_index),
		.rand_x     (rand_x),
		.rand_y     (rand_y),
		.rand_z     (rand_z),
		.rand_level (rand_level),
		.disp_width (width_q),
		.q_count    (status.count),
		.push       (push)
	);

	sfps_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.status (status)
	);

	sfps_back #(.NUM_STARS(NUM_STARS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.disp_width  (width_q),
		.disp_height (height_q),
		.status      (status),
		.pop         (pop),
		.done        (done),
		.pixel_valid (pixel_valid),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.gray        (gray),
		.respawned   (respawned)
	);

endmodule

`default_nettype wire

[design/sfps_ram.sv]
// ----------------------------------------------------------------------------
// sfps_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfps_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 64
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[design/sfps_front.sv]
// ----------------------------------------------------------------------------
// sfps_front
// Accepts commands, checks the star index and reduces the random words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfps_front #(
	parameter int NUM_STARS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          cmd,
	input  wire logic [sfps_pkg::IDX_W-1:0]    star_index,
	input  wire logic [31:0]                   rand_x,
	input  wire logic [31:0]                   rand_y,
	input  wire logic [31:0]                   rand_z,
	input  wire logic [7:0]                    rand_level,
	input  wire logic [sfps_pkg::CFG_W-1:0]    disp_width,
	input  wire logic [sfps_pkg::QCNT_W-1:0]   q_count,
	output sfps_pkg::push_t                    push
);

	localparam int QCNT_W_L = sfps_pkg::QCNT_W + 1;

	logic                       v_s1, v_s2, v_s3;
	logic                       cmd_s1, cmd_s2, cmd_s3;
	logic                       inr_s1, inr_s2, inr_s3;
	logic                       wide_s1, wide_s2, wide_s3;
	logic [sfps_pkg::IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic [7:0]                 lvl_s1, lvl_s2, lvl_s3;
	logic [31:0]                rx_s1, ry_s1, rz_s1;
	logic [31:0]                rx_s2, ry_s2, rz_s2;
	logic [25:0]                qx_s2, qy_s2, qz_s2;
	logic [9:0]                 rx_s3, ry_s3, rz_s3;

	logic        accept;
	logic [31:0] recip_s1;
	logic [63:0] prod_x, prod_y, prod_z;
	logic [8:0]  spread_s2, spread_s3, half_s3;
	logic [34:0] qd_x, qd_y, qd_z;
	logic [9:0]  fx, fy, fz;
	logic [QCNT_W_L-1:0] occ;

	assign occ    = QCNT_W_L'(q_count) + QCNT_W_L'(v_s1) + QCNT_W_L'(v_s2)
		+ QCNT_W_L'(v_s3);
	assign busy   = occ >= QCNT_W_L'(sfps_pkg::QUEUE_DEPTH);
	assign accept = start && !busy;

	assign recip_s1  = wide_s1 ? sfps_pkg::RECIP_WIDE : sfps_pkg::RECIP_NARROW;
	assign prod_x    = {32'd0, rx_s1} * {32'd0, recip_s1};
	assign prod_y    = {32'd0, ry_s1} * {32'd0, recip_s1};
	assign prod_z    = {32'd0, rz_s1} * {32'd0, sfps_pkg::RECIP_DEPTH};

	assign spread_s2 = wide_s2 ? sfps_pkg::SPREAD_WIDE : sfps_pkg::SPREAD_NARROW;
	assign qd_x      = qx_s2 * spread_s2;
	assign qd_y      = qy_s2 * spread_s2;
	assign qd_z      = qz_s2 * sfps_pkg::DEPTH_MOD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd;
			idx_s1  <= star_index;
			inr_s1  <= int'(star_index) < NUM_STARS;
			wide_s1 <= disp_width > sfps_pkg::WIDE_LIMIT;
			rx_s1   <= rand_x;
			ry_s1   <= rand_y;
			rz_s1   <= rand_z;
			lvl_s1  <= rand_level;
		end
		cmd_s2  <= cmd_s1;
		idx_s2  <= idx_s1;
		inr_s2  <= inr_s1;
		wide_s2 <= wide_s1;
		lvl_s2  <= lvl_s1;
		rx_s2   <= rx_s1;
		ry_s2   <= ry_s1;
		rz_s2   <= rz_s1;
		qx_s2   <= prod_x[57:32];
		qy_s2   <= prod_y[57:32];
		qz_s2   <= prod_z[57:32];
		cmd_s3  <= cmd_s2;
		idx_s3  <= idx_s2;
		inr_s3  <= inr_s2;
		wide_s3 <= wide_s2;
		lvl_s3  <= lvl_s2;
		// The true remainder is below twice the divisor, so ten bits hold it.
		rx_s3   <= 10'(rx_s2 - 32'(qd_x));
		ry_s3   <= 10'(ry_s2 - 32'(qd_y));
		rz_s3   <= 10'(rz_s2 - 32'(qd_z));
	end

	assign spread_s3 = wide_s3 ? sfps_pkg::SPREAD_WIDE : sfps_pkg::SPREAD_NARROW;
	assign half_s3   = wide_s3 ? sfps_pkg::HALF_WIDE : sfps_pkg::HALF_NARROW;
	assign fx = (rx_s3 >= {1'b0, spread_s3}) ? rx_s3 - {1'b0, spread_s3} : rx_s3;
	assign fy = (ry_s3 >= {1'b0, spread_s3}) ? ry_s3 - {1'b0, spread_s3} : ry_s3;
	assign fz = (rz_s3 >= {1'b0, sfps_pkg::DEPTH_MOD}) ?
		rz_s3 - {1'b0, sfps_pkg::DEPTH_MOD} : rz_s3;

	always_comb begin
		push.valid               = v_s3;
		push.item.cmd            = cmd_s3;
		push.item.in_range       = inr_s3;
		push.item.idx            = idx_s3;
		push.item.spawn.x        = 9'(fx - {1'b0, half_s3});
		push.item.spawn.y        = 9'(fy - {1'b0, half_s3});
		push.item.spawn.z        = fz + sfps_pkg::DEPTH_BASE;
		push.item.spawn.level    = lvl_s3;
	end

endmodule

`default_nettype wire

[design/sfps_queue.sv]
// ----------------------------------------------------------------------------
// sfps_queue
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfps_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sfps_pkg::push_t push,
	input  wire logic            pop,
	output sfps_pkg::q_status_t  status
);

	localparam int PW = $clog2(sfps_pkg::QUEUE_DEPTH);

	sfps_pkg::item_t             slot_q [0:sfps_pkg::QUEUE_DEPTH-1];
	logic [PW-1:0]               wr_q, rd_q;
	logic [sfps_pkg::QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + sfps_pkg::QCNT_W'(push.valid) - sfps_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wr_q] <= push.item;
		end
	end

	assign status.empty = cnt_q == '0;
	assign status.count = cnt_q;
	assign status.head  = slot_q[rd_q];

endmodule

`default_nettype wire

[design/sfps_back.sv]
// ----------------------------------------------------------------------------
// sfps_back
// Reads the star, advances and projects it, writes it back and reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfps_back #(
	parameter int NUM_STARS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [sfps_pkg::CFG_W-1:0]    disp_width,
	input  wire logic [sfps_pkg::CFG_W-1:0]    disp_height,
	input  wire sfps_pkg::q_status_t           status,
	output logic                               pop,
	output logic                               done,
	output logic                               pixel_valid,
	output logic [sfps_pkg::PIX_W-1:0]         pixel_x,
	output logic [sfps_pkg::PIX_W-1:0]         pixel_y,
	output logic [7:0]                         gray,
	output logic                               respawned
);

	localparam int AW = NUM_STARS > 1 ? $clog2(NUM_STARS) : 1;
	localparam int ND = sfps_pkg::DIV_STEPS;

	typedef struct packed {
		sfps_pkg::item_t it;
		sfps_pkg::star_t cur;
		logic            alive;
		logic            nx;
		logic            ny;
		logic [ND-1:0]   mx;
		logic [ND-1:0]   my;
		logic [8:0]      dz;
		logic [8:0]      rx;
		logic [8:0]      ry;
		logic [ND-1:0]   qx;
		logic [ND-1:0]   qy;
	} dv_t;

	// One restoring divide step on both quotients, most significant bit first.
	function automatic dv_t div_step(dv_t a, int unsigned k);
		dv_t        r;
		logic [9:0] tx, ty;
		r  = a;
		tx = {a.rx, a.mx[ND-1-k]};
		ty = {a.ry, a.my[ND-1-k]};
		if (tx >= {1'b0, a.dz}) begin
			r.rx = 9'(tx - {1'b0, a.dz});
		end else begin
			r.rx = tx[8:0];
		end
		if (ty >= {1'b0, a.dz}) begin
			r.ry = 9'(ty - {1'b0, a.dz});
		end else begin
			r.ry = ty[8:0];
		end
		r.qx = {a.qx[ND-2:0], tx >= {1'b0, a.dz}};
		r.qy = {a.qy[ND-2:0], ty >= {1'b0, a.dz}};
		return r;
	endfunction

	logic            v_s1;
	sfps_pkg::item_t it_s1;
	logic [35:0]     rd_data;
	sfps_pkg::star_t rd_star;
	logic            v_div_s [0:ND];
	dv_t             div_s   [0:ND];

	logic                     hazard;
	logic signed [10:0]       z7;
	logic [7:0]               scale;
	logic signed [17:0]       prx, pry;
	logic [17:0]              abx, aby;
	dv_t                      ld, last;
	logic signed [16:0]       sx, sy, px, py;
	logic                     off, draw, we;
	sfps_pkg::star_t          wstar;
	logic [15:0]              gprod;
	logic [3:0]               gq;

	always_comb begin
		hazard = v_s1 && (it_s1.idx == status.head.idx);
		for (int k = 0; k <= ND; k++) begin
			hazard = hazard || (v_div_s[k] && (div_s[k].it.idx == status.head.idx));
		end
	end
	assign pop = !status.empty && !hazard;

	sfps_ram #(.WIDTH(36), .DEPTH(NUM_STARS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(last.it.idx)),
		.wdata (wstar),
		.raddr (AW'(status.head.idx)),
		.rdata (rd_data)
	);

	assign rd_star = rd_data;
	assign z7      = $signed({1'b0, rd_star.z}) - $signed(sfps_pkg::Z_STEP);
	assign scale   = (disp_width > sfps_pkg::WIDE_LIMIT) ?
		sfps_pkg::SCALE_WIDE : sfps_pkg::SCALE_NARROW;
	assign prx     = 18'(rd_star.x) * $signed({10'd0, scale});
	assign pry     = 18'(rd_star.y) * $signed({10'd0, scale});
	assign abx     = prx[17] ? 18'(-prx) : 18'(prx);
	assign aby     = pry[17] ? 18'(-pry) : 18'(pry);

	always_comb begin
		ld           = '0;
		ld.it        = it_s1;
		ld.cur       = rd_star;
		ld.cur.z     = z7[9:0];
		ld.alive     = (it_s1.cmd == sfps_pkg::CMD_STEP) && it_s1.in_range && (z7 > 11'sd0);
		ld.nx        = prx[17];
		ld.ny        = pry[17];
		ld.mx        = abx[ND-1:0];
		ld.my        = aby[ND-1:0];
		ld.dz        = z7[8:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k <= ND; k++) begin
				v_div_s[k] <= 1'b0;
			end
		end else begin
			v_s1       <= pop;
			v_div_s[0] <= v_s1;
			for (int k = 1; k <= ND; k++) begin
				v_div_s[k] <= v_div_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			it_s1 <= status.head;
		end
		div_s[0] <= ld;
	end

	for (genvar g = 0; g < ND; g++) begin : g_div
		always_ff @(posedge clk) begin
			div_s[g+1] <= div_step(div_s[g], g);
		end
	end

	assign last = div_s[ND];
	assign sx   = last.nx ? -$signed({2'b00, last.qx}) : $signed({2'b00, last.qx});
	assign sy   = last.ny ? -$signed({2'b00, last.qy}) : $signed({2'b00, last.qy});
	assign px   = sx + $signed({8'd0, disp_width[9:1]});
	assign py   = sy + $signed({8'd0, disp_height[9:1]});
	assign off  = px[16] || py[16] || (px >= $signed({7'd0, disp_width}))
		|| (py >= $signed({7'd0, disp_height}));
	assign draw = last.alive && !off;
	assign we   = v_div_s[ND] && last.it.in_range;
	assign wstar = draw ? last.cur : last.it.spawn;
	assign gprod = {8'd0, last.cur.level} * {8'd0, sfps_pkg::GRAY_RECIP};
	assign gq    = gprod[sfps_pkg::GRAY_SHIFT +: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done        <= 1'b0;
			pixel_valid <= 1'b0;
			respawned   <= 1'b0;
			pixel_x     <= '0;
			pixel_y     <= '0;
			gray        <= '0;
		end else begin
			done        <= v_div_s[ND];
			pixel_valid <= v_div_s[ND] && draw;
			respawned   <= v_div_s[ND] && last.it.in_range && !draw;
			pixel_x     <= (v_div_s[ND] && draw) ? px[8:0] : '0;
			pixel_y     <= (v_div_s[ND] && draw) ? py[8:0] : '0;
			gray        <= (v_div_s[ND] && draw) ? {gq, gq} : '0;
		end
	end

endmodule

`default_nettype wire

[design/sfps_checker.sv]
// ----------------------------------------------------------------------------
// sfps_checker
// Port-level checks on the result channel of the starfield block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "starfield_projection_step_top_defines.svh"

module sfps_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       busy,
	input wire logic       done,
	input wire logic       pixel_valid,
	input wire logic [8:0] pixel_x,
	input wire logic [8:0] pixel_y,
	input wire logic [7:0] gray,
	input wire logic       respawned
);

	// A drawn pixel and a respawn never come from the same word.
	`SFPS_ASSERT(a_draw_or_respawn, !(pixel_valid && respawned), "pixel drawn on respawn")
	// Result flags only stand while the strobe is high.
	`SFPS_ASSERT(a_flags_strobed, done || (!pixel_valid && !respawned), "flag without done")
	// Without a pixel, all coordinates and the gray level read zero.
	`SFPS_ASSERT(a_zero_fields, pixel_valid || (pixel_x == 9'd0 && pixel_y == 9'd0 && gray == 8'd0), "stale pixel fields")
	// Gray is a multiple of 17, so both nibbles match.
	`SFPS_ASSERT(a_gray_step, gray[7:4] == gray[3:0], "gray not a multiple of 17")
	// Reset leaves no result and an open command channel.
	`SFPS_ASSERT_RST(a_reset_idle, !done && !busy, "activity after reset")

endmodule

bind starfield_projection_step_top sfps_checker u_sfps_checker (.*);

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the starfield projection block.
// Stars are spawned and stepped in bursts under several display settings.
// Each result word is compared with a local model of the star table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	typedef struct {
		logic       pix_on;
		logic [8:0] col;
		logic [8:0] row;
		logic [7:0] shade;
		logic       reborn;
	} pixel_word_t;

	class pixel_scoreboard;
		int          star_x [64];
		int          star_y [64];
		int          star_z [64];
		int          star_lvl [64];
		int          disp_w;
		int          disp_h;
		pixel_word_t pending [$];
		int          mismatches;
		int          pixels;
		int          reborns;

		function new();
			disp_w = 128;
			disp_h = 128;
		endfunction

		function void set_reg(sfps_pkg::reg_idx_t r, int v);
			if (r == sfps_pkg::REG_DISPLAY_WIDTH)
				disp_w = v;
			else
				disp_h = v;
		endfunction

		function void place_star(int i, logic [31:0] rx, logic [31:0] ry,
				logic [31:0] rz, logic [7:0] rl);
			int spread;
			spread = (disp_w > 128) ? 300 : 200;
			star_x[i]   = int'(rx % spread) - spread / 2;
			star_y[i]   = int'(ry % spread) - spread / 2;
			star_z[i]   = int'(rz % 400) + 100;
			star_lvl[i] = int'(rl);
		endfunction

		// Predict the result word of one accepted command.
		function void project_star(logic c, int i, logic [31:0] rx, logic [31:0] ry,
				logic [31:0] rz, logic [7:0] rl);
			pixel_word_t w;
			int scale, px, py;
			w = '{1'b0, 9'd0, 9'd0, 8'd0, 1'b0};
			if (c == sfps_pkg::CMD_SPAWN) begin
				place_star(i, rx, ry, rz, rl);
				w.reborn = 1'b1;
			end else begin
				star_z[i] -= 7;
				if (star_z[i] < 1) begin
					place_star(i, rx, ry, rz, rl);
					w.reborn = 1'b1;
				end else begin
					scale = (disp_w > 128) ? 150 : 100;
					px = (star_x[i] * scale) / star_z[i] + disp_w / 2;
					py = (star_y[i] * scale) / star_z[i] + disp_h / 2;
					if (px < 0 || py < 0 || px >= disp_w || py >= disp_h) begin
						place_star(i, rx, ry, rz, rl);
						w.reborn = 1'b1;
					end else begin
						w.pix_on = 1'b1;
						w.col    = px[8:0];
						w.row    = py[8:0];
						w.shade  = 8'(((star_lvl[i] * 15) / 255) * 17);
					end
				end
			end
			pending.push_back(w);
		endfunction

		function void check(pixel_word_t got);
			pixel_word_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result word with nothing outstanding");
				return;
			end
			want = pending.pop_front();
			if (want.reborn) reborns++;
			if (want.pix_on) pixels++;
			if (got.pix_on !== want.pix_on || got.col !== want.col || got.row !== want.row
					|| got.shade !== want.shade || got.reborn !== want.reborn) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"ERROR: exp v=%0d x=%0d y=%0d g=%0d r=%0d ",
						"got v=%0d x=%0d y=%0d g=%0d r=%0d"},
						want.pix_on, want.col, want.row, want.shade, want.reborn,
						got.pix_on, got.col, got.row, got.shade, got.reborn);
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	logic                            cmd;
	logic [sfps_pkg::IDX_W-1:0]      star_index;
	logic [31:0]                     rand_x, rand_y, rand_z;
	logic [7:0]                      rand_level;
	logic                            done;
	logic                            pixel_valid;
	logic [sfps_pkg::PIX_W-1:0]      pixel_x, pixel_y;
	logic [7:0]                      gray;
	logic                            respawned;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic                            cfg_index;
	logic [sfps_pkg::CFG_W-1:0]      cfg_data;

	pixel_scoreboard sb;
	bit  spawned [64];
	int  idle_cycles;
	int  items_sent;
	int  sub_base;
	int  sub_size;

	localparam int DRAIN_CYCLES = 40;
	localparam int WATCHDOG     = 5000;

	starfield_projection_step_top uut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result words are strobed for one cycle and cannot be held off.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check('{pixel_valid, pixel_x, pixel_y, gray, respawned});
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_cmd(logic c, int i, logic [31:0] rx, logic [31:0] ry,
			logic [31:0] rz, logic [7:0] rl);
		start      <= 1'b1;
		cmd        <= c;
		star_index <= sfps_pkg::IDX_W'(i);
		rand_x     <= rx;
		rand_y     <= ry;
		rand_z     <= rz;
		rand_level <= rl;
		do @(posedge clk); while (busy);
		sb.project_star(c, i, rx, ry, rz, rl);
		if (c == sfps_pkg::CMD_SPAWN) spawned[i] = 1'b1;
		items_sent++;
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Registers change only once the pipeline has drained.
	task automatic write_reg(sfps_pkg::reg_idx_t r, int v);
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data  <= sfps_pkg::CFG_W'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reg(r, v);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 600);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_burst();
		int n, i;
		n = $urandom_range(1, 20);
		repeat (n) begin
			i = sub_base + $urandom_range(0, sub_size - 1);
			if (i > 63) i = 63;
			if (!spawned[i] || $urandom_range(0, 9) == 0)
				send_cmd(sfps_pkg::CMD_SPAWN, i, pick_word(), pick_word(), pick_word(),
					8'($urandom));
			else
				send_cmd(sfps_pkg::CMD_STEP, i, pick_word(), pick_word(), pick_word(),
					8'($urandom));
		end
		if ($urandom_range(0, 3) != 0)
			pause($urandom_range(1, 6));
	endtask

	initial begin
		int widths [8];
		int heights [8];
		int p, k;
		widths  = '{128, 129, 512, 1, 0, 1023, 200, 64};
		heights = '{128, 100, 512, 1, 0, 1023, 64, 300};
		sb = new();
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = sfps_pkg::CMD_SPAWN;
		star_index = '0;
		rand_x     = '0;
		rand_y     = '0;
		rand_z     = '0;
		rand_level = '0;
		cfg_valid  = 1'b0;
		cfg_index  = sfps_pkg::REG_DISPLAY_WIDTH;
		cfg_data   = '0;
		idle_cycles = 0;
		items_sent  = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, then one star stepped until it passes the viewer.
		send_cmd(sfps_pkg::CMD_SPAWN, 0, 32'd0, 32'd0, 32'd0, 8'd0);
		send_cmd(sfps_pkg::CMD_SPAWN, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			8'd255);
		send_cmd(sfps_pkg::CMD_SPAWN, 21, 32'd100, 32'd100, 32'd0, 8'd255);
		send_cmd(sfps_pkg::CMD_SPAWN, 42, 32'd199, 32'd0, 32'd399, 8'd128);
		send_cmd(sfps_pkg::CMD_STEP, 0, 32'd0, 32'd0, 32'd0, 8'd0);
		send_cmd(sfps_pkg::CMD_STEP, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			8'd255);
		send_cmd(sfps_pkg::CMD_STEP, 42, 32'd5, 32'd5, 32'd5, 8'd5);
		for (k = 0; k < 16; k++)
			send_cmd(sfps_pkg::CMD_STEP, 21, 32'd100, 32'd100, 32'd0, 8'd255);
		pause(3);

		for (p = 0; p < 8; p++) begin
			if (p != 0) begin
				write_reg(sfps_pkg::REG_DISPLAY_WIDTH, widths[p]);
				write_reg(sfps_pkg::REG_DISPLAY_HEIGHT, heights[p]);
			end
			// Small star subsets get many steps each, so stars reach the viewer.
			sub_size = (p % 2 == 0) ? $urandom_range(2, 6) : 64;
			sub_base = (sub_size == 64) ? 0 : $urandom_range(0, 64 - sub_size);
			while (items_sent < 25 + (p + 1) * 185)
				random_burst();
		end

		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d commands over 8 display settings: %0d pixels drawn, %0d respawns.",
			items_sent, sb.pixels, sb.reborns);
		if (sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
